// ----- rtl/ptsa_pkg.sv -----
// Package for the pencil transpose scatter addresser.
// Holds sizes, codes, state and command types shared by all modules.
// Depends on nothing.
`default_nettype none
package ptsa_pkg;
  localparam int MAX_RANKS  = 64;
  localparam int RANK_BITS  = 6;
  localparam int DIM_BITS   = 10;
  localparam int NODE_BITS  = 6;
  localparam int MAX_FIELDS = 8;
  localparam int WPP_BITS   = 4;
  localparam int WORD_W     = 34;
  localparam int ADDR_W     = 33;
  localparam int DIMS_W     = 3 * DIM_BITS;
  localparam int GRID_W     = 3 * NODE_BITS;
  localparam int CFG_W      = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_W      = DIM_BITS + NODE_BITS + 1;
  localparam int M1_W       = 2 * DIM_BITS;
  localparam int M2_W       = 3 * DIM_BITS + 1;
  localparam int SRC_W      = M2_W + 1 + WPP_BITS;
  localparam int R1_W       = 2 * NODE_BITS + 1;
  localparam int RANK_W     = 3 * NODE_BITS + 2;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(1049601);
  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(4161);

  typedef enum logic [1:0] {
    ACT_CLEAR, ACT_COUNT, ACT_OFFSETS, ACT_EMIT
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_DIMS, CFG_OUT_DIMS, CFG_OWN_COORDS, CFG_OUT_GRID, CFG_IN_AXIS, CFG_FIELDS
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DIV, ST_RANK0, ST_RANK1, ST_READ, ST_UPDATE,
    ST_SW_RD, ST_SW_WR, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_DIV, OP_RANK0, OP_RANK1, OP_READ, OP_UPDATE,
    OP_SW_RD, OP_SW_WR, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [RANK_BITS-1:0] idx;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/ptsa_if.sv -----
// Request channel interfaces for the pencil transpose scatter addresser.
// Depends on ptsa_pkg for field widths.
`default_nettype none
interface ptsa_point_if;
  import ptsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [DIM_BITS-1:0] coord_0;
  logic [DIM_BITS-1:0] coord_1;
  logic [DIM_BITS-1:0] coord_2;
  modport source (output valid, action, coord_0, coord_1, coord_2, input ready);
  modport sink (input valid, action, coord_0, coord_1, coord_2, output ready);
endinterface

interface ptsa_result_if;
  import ptsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [RANK_BITS-1:0] dst_rank;
  logic [ADDR_W-1:0]    buffer_addr;
  logic [ADDR_W-1:0]    source_addr;
  logic                 error;
  modport source (output valid, dst_rank, buffer_addr, source_addr, error, input ready);
  modport sink (input valid, dst_rank, buffer_addr, source_addr, error, output ready);
endinterface
`default_nettype wire

// ----- rtl/ptsa_ctrl.sv -----
// Controller state machine of the pencil transpose scatter addresser.
// Sequences the datapath by commands; depends on ptsa_pkg.
`default_nettype none
module ptsa_ctrl
  import ptsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t               state, state_next;
  logic [RANK_BITS-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_next = '0;
        unique case (sts.act)
          ACT_CLEAR: begin
            cmd.op     = OP_CLEAR;
            state_next = ST_FINISH;
          end
          ACT_OFFSETS: state_next = ST_SW_RD;
          default:     state_next = ST_DIV;
        endcase
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt == RANK_BITS'(DIV_W - 1)) begin
          state_next = ST_RANK0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RANK0: begin
        cmd.op     = OP_RANK0;
        state_next = ST_RANK1;
      end
      ST_RANK1: begin
        cmd.op     = OP_RANK1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.op     = OP_READ;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op     = OP_UPDATE;
        state_next = ST_FINISH;
      end
      ST_SW_RD: begin
        cmd.op     = OP_SW_RD;
        state_next = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd.op = OP_SW_WR;
        if (cnt == RANK_BITS'(MAX_RANKS - 1)) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_SW_RD;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/ptsa_dpath.sv -----
// Datapath of the pencil transpose scatter addresser: configuration, dividers,
// multiply chain, rank word table and result register. Depends on ptsa_pkg.
`default_nettype none
module ptsa_dpath
  import ptsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [CFG_IDX_W-1:0] reg_index,
  input  wire logic [CFG_W-1:0]     write_data,
  input  wire logic [1:0]           action,
  input  wire logic [DIM_BITS-1:0]  coord_0,
  input  wire logic [DIM_BITS-1:0]  coord_1,
  input  wire logic [DIM_BITS-1:0]  coord_2,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [RANK_BITS-1:0]      out_rank,
  output logic [ADDR_W-1:0]         out_buf,
  output logic [ADDR_W-1:0]         out_src,
  output logic                      out_err
);
  logic [DIMS_W-1:0]   in_dims, out_dims;
  logic [GRID_W-1:0]   own_coords, out_grid;
  logic [1:0]          in_axis;
  logic [WPP_BITS-1:0] fields;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_dims    <= DIMS_RESET;
      out_dims   <= DIMS_RESET;
      own_coords <= '0;
      out_grid   <= GRID_RESET;
      in_axis    <= '0;
      fields     <= WPP_BITS'(1);
    end else if (write_enable) begin
      unique case (reg_index)
        CFG_IN_DIMS:    in_dims    <= write_data[DIMS_W-1:0];
        CFG_OUT_DIMS:   out_dims   <= write_data[DIMS_W-1:0];
        CFG_OWN_COORDS: own_coords <= write_data[GRID_W-1:0];
        CFG_OUT_GRID:   out_grid   <= write_data[GRID_W-1:0];
        CFG_IN_AXIS:    in_axis    <= write_data[1:0];
        CFG_FIELDS:     fields     <= write_data[WPP_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_BITS-1:0]  n [3];
  logic [DIM_BITS-1:0]  od [3];
  logic [NODE_BITS-1:0] g [3];
  logic [NODE_BITS-1:0] own [3];
  logic [DIM_BITS-1:0]  cin [3];
  logic [WPP_BITS-1:0]  wpp;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k]   = in_dims[k*DIM_BITS +: DIM_BITS];
      od[k]  = out_dims[k*DIM_BITS +: DIM_BITS];
      g[k]   = out_grid[k*NODE_BITS +: NODE_BITS];
      own[k] = own_coords[k*NODE_BITS +: NODE_BITS];
    end
    cin[0] = coord_0;
    cin[1] = coord_1;
    cin[2] = coord_2;
    wpp = (fields > WPP_BITS'(MAX_FIELDS)) ? WPP_BITS'(MAX_FIELDS) : fields;
  end

  act_t                act;
  logic [DIM_BITS-1:0] c [3];
  logic [DIV_W-1:0]    q [3];
  logic [DIM_BITS-1:0] rem [3];
  logic [2:0]          cerr;
  logic                derr, err;
  logic [M1_W-1:0]     m1;
  logic [M2_W-1:0]     m2;
  logic [ADDR_W-1:0]   src;
  logic [R1_W-1:0]     r1;
  logic [RANK_W-1:0]   rank;
  logic [WORD_W-1:0]   bufr;
  logic [WORD_W-1:0]   offset_sum;

  logic [1:0] a0, a1, a2;
  always_comb begin
    a0 = (in_axis == 2'd3) ? 2'd0 : in_axis;
    a1 = (a0 == 2'd2) ? 2'd0 : a0 + 2'd1;
    a2 = (a1 == 2'd2) ? 2'd0 : a1 + 2'd1;
  end

  logic [DIM_BITS:0] trial [3];
  logic [2:0]        ge;
  logic [M2_W:0]     sum2;
  logic [SRC_W-1:0]  prod;
  logic              derr_now;
  always_comb begin
    derr_now = 1'b0;
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem[k], q[k][DIV_W-1]};
      ge[k]    = trial[k] >= {1'b0, od[k]};
      if (od[k] == '0 || q[k] >= DIV_W'(g[k])) derr_now = 1'b1;
    end
    sum2 = {1'b0, m2} + (M2_W+1)'(c[a0]);
    prod = SRC_W'(sum2) * SRC_W'(wpp);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act <= act_t'(action);
        for (int k = 0; k < 3; k++) begin
          c[k]    <= cin[k];
          q[k]    <= DIV_W'(own[k]) * DIV_W'(n[k]) + DIV_W'(cin[k]);
          rem[k]  <= '0;
          cerr[k] <= cin[k] >= n[k];
        end
      end
      OP_DIV: begin
        for (int k = 0; k < 3; k++) begin
          rem[k] <= ge[k] ? DIM_BITS'(trial[k] - {1'b0, od[k]}) : trial[k][DIM_BITS-1:0];
          q[k]   <= {q[k][DIV_W-2:0], ge[k]};
        end
        if (cmd.idx == RANK_BITS'(0)) begin
          m1 <= M1_W'(n[a1]) * M1_W'(c[a2]);
        end else if (cmd.idx == RANK_BITS'(1)) begin
          m2 <= M2_W'(M2_W'(n[a0]) * (M2_W'(m1) + M2_W'(c[a1])));
        end else if (cmd.idx == RANK_BITS'(2)) begin
          src <= prod[ADDR_W-1:0];
        end
      end
      OP_RANK0: begin
        derr <= derr_now;
        r1 <= R1_W'(g[1]) * R1_W'(q[2][NODE_BITS-1:0]) + R1_W'(q[1][NODE_BITS-1:0]);
      end
      OP_RANK1: begin
        rank <= RANK_W'(g[0]) * RANK_W'(r1) + RANK_W'(q[0][NODE_BITS-1:0]);
      end
      OP_READ: begin
        err <= (|cerr) || derr || (rank >= RANK_W'(MAX_RANKS));
      end
      default: ;
    endcase
  end

  logic [WORD_W-1:0]    mem [MAX_RANKS];
  logic [MAX_RANKS-1:0] vld;
  logic [WORD_W-1:0]    rd_data, entry;
  logic                 rd_vld;
  logic [RANK_BITS-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic                 wr_en;

  always_comb begin
    rd_addr = (cmd.op == OP_READ) ? rank[RANK_BITS-1:0] : cmd.idx;
    entry   = rd_vld ? rd_data : '0;
    wr_en   = 1'b0;
    wr_addr = cmd.idx;
    wr_data = offset_sum;
    if (cmd.op == OP_UPDATE && !err) begin
      wr_en   = 1'b1;
      wr_addr = rank[RANK_BITS-1:0];
      wr_data = entry + WORD_W'(wpp);
    end else if (cmd.op == OP_SW_WR) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_CLEAR) begin
      vld        <= '0;
      offset_sum <= '0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (cmd.op == OP_SW_RD && cmd.idx == '0) offset_sum <= '0;
      else if (cmd.op == OP_SW_WR) offset_sum <= offset_sum + entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPDATE) bufr <= err ? '0 : entry;
  end

  logic point_act;
  assign point_act = (act == ACT_COUNT) || (act == ACT_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_err  <= point_act && err;
      out_rank <= (point_act && !err) ? rank[RANK_BITS-1:0] : '0;
      out_buf  <= (act == ACT_EMIT && !err) ? bufr[ADDR_W-1:0] : '0;
      out_src  <= point_act ? src : '0;
    end
  end

  assign sts.act      = act;
  assign sts.out_free = !out_valid || out_ready;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_CLEAR |=> vld == '0)
    else $error("table not empty after clear");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |=> out_valid)
    else $error("result not presented after finish");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_rank == '0 && out_buf == '0)
    else $error("error result carries a rank or buffer address");
endmodule
`default_nettype wire

// ----- rtl/pencil_transpose_scatter_addresser.sv -----
// Top level of the pencil transpose scatter addresser.
// Joins ptsa_ctrl and ptsa_dpath; depends on ptsa_pkg and ptsa_if.
//
//   Channel   Dir  Carries
//   points    in   action, coord_0..coord_2 (request)
//   results   out  dst_rank, buffer_addr, source_addr, error
//   config    in   write_enable, reg_index, write_data
//
// Count and emit go from accept through dispatch, the 17-step shared-counter divider
// and the rank multiply chain, then read, update and finish. Clear goes from dispatch
// to finish. Offsets make one read and one write of the table per rank.
// Reset is synchronous and clears the table through its valid bits at once.
// A held result stalls only the finishing step; one request is in work at a time.
`default_nettype none
module pencil_transpose_scatter_addresser
  import ptsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [CFG_IDX_W-1:0] reg_index,
  input  wire logic [CFG_W-1:0]     write_data,
  ptsa_point_if.sink                points,
  ptsa_result_if.source             results
);
  cmd_t cmd;
  sts_t sts;

  ptsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptsa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .action       (points.action),
    .coord_0      (points.coord_0),
    .coord_1      (points.coord_1),
    .coord_2      (points.coord_2),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .out_rank     (results.dst_rank),
    .out_buf      (results.buffer_addr),
    .out_src      (results.source_addr),
    .out_err      (results.error)
  );
endmodule
`default_nettype wire

// ----- tb/tb_pencil_transpose_scatter_addresser.sv -----
// Testbench for the pencil transpose scatter addresser: drives point requests and
// register writes, predicts each result from its own table model and checks it.
// Depends on ptsa_pkg, ptsa_if and the RTL top level.
`default_nettype none
module tb_pencil_transpose_scatter_addresser;
  import ptsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);
  localparam int ITEM_TARGET = 750;

  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [ADDR_W-1:0]    buf_addr;
    logic [ADDR_W-1:0]    src_addr;
    logic                 err;
  } scatter_t;

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0] write_data;

  ptsa_point_if  pts();
  ptsa_result_if res();

  pencil_transpose_scatter_addresser dut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .reg_index(reg_index),
    .write_data(write_data), .points(pts), .results(res)
  );

  always #10 clk = ~clk;

  logic [WORD_W-1:0] rank_table [MAX_RANKS];
  logic [DIMS_W-1:0] in_dims_r, out_dims_r;
  logic [GRID_W-1:0] own_r, grid_r;
  logic [1:0] axis_r;
  logic [3:0] fields_r;

  scatter_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_request = 0;
  int hold_left = 0;

  function automatic scatter_t predict_scatter(act_t act, logic [DIM_BITS-1:0] c0,
                                               logic [DIM_BITS-1:0] c1,
                                               logic [DIM_BITS-1:0] c2);
    scatter_t r;
    logic [63:0] c [3];
    logic [63:0] n [3];
    logic [63:0] d [3];
    logic [63:0] g [3];
    logic [63:0] od, wpp, rank, src;
    logic [WORD_W-1:0] acc;
    int a0, a1, a2;
    bit err;
    r = '0;
    err = 1'b0;
    if (act == ACT_CLEAR) begin
      foreach (rank_table[i]) rank_table[i] = '0;
      return r;
    end
    if (act == ACT_OFFSETS) begin
      acc = '0;
      for (int i = 0; i < MAX_RANKS; i++) begin
        logic [WORD_W-1:0] t;
        t = rank_table[i];
        rank_table[i] = acc;
        acc = acc + t;
      end
      return r;
    end
    wpp = (fields_r > MAX_FIELDS) ? 64'(MAX_FIELDS) : 64'(fields_r);
    c[0] = 64'(c0);
    c[1] = 64'(c1);
    c[2] = 64'(c2);
    for (int k = 0; k < 3; k++) begin
      n[k] = 64'(in_dims_r[k*DIM_BITS +: DIM_BITS]);
      g[k] = 64'(grid_r[k*NODE_BITS +: NODE_BITS]);
      od = 64'(out_dims_r[k*DIM_BITS +: DIM_BITS]);
      if (c[k] >= n[k]) err = 1'b1;
      if (od == 0) begin
        err = 1'b1;
        d[k] = 0;
      end else begin
        d[k] = (64'(own_r[k*NODE_BITS +: NODE_BITS]) * n[k] + c[k]) / od;
      end
      if (d[k] >= g[k]) err = 1'b1;
    end
    a0 = (axis_r == 2'd3) ? 0 : int'(axis_r);
    a1 = (a0 + 1) % 3;
    a2 = (a0 + 2) % 3;
    src = (c[a0] + n[a0] * (c[a1] + n[a1] * c[a2])) * wpp;
    rank = d[0] + g[0] * (d[1] + g[1] * d[2]);
    if (rank >= MAX_RANKS) err = 1'b1;
    if (!err) begin
      if (act == ACT_EMIT) r.buf_addr = rank_table[rank][ADDR_W-1:0];
      rank_table[rank] = rank_table[rank] + WORD_W'(wpp);
      r.rank = rank[RANK_BITS-1:0];
    end
    r.src_addr = src[ADDR_W-1:0];
    r.err = err;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    @(posedge clk);
    case (idx)
      CFG_IN_DIMS:    in_dims_r = value[DIMS_W-1:0];
      CFG_OUT_DIMS:   out_dims_r = value[DIMS_W-1:0];
      CFG_OWN_COORDS: own_r = value[GRID_W-1:0];
      CFG_OUT_GRID:   grid_r = value[GRID_W-1:0];
      CFG_IN_AXIS:    axis_r = value[1:0];
      CFG_FIELDS:     fields_r = value[3:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(act_t act, logic [DIM_BITS-1:0] c0, logic [DIM_BITS-1:0] c1,
                            logic [DIM_BITS-1:0] c2);
    while (src_gaps && $urandom_range(99) < 25) begin
      pts.valid <= 1'b0;
      @(posedge clk);
    end
    pts.valid <= 1'b1;
    pts.action <= act;
    pts.coord_0 <= c0;
    pts.coord_1 <= c1;
    pts.coord_2 <= c2;
    do @(posedge clk); while (!pts.ready);
    pending_results.push_back(predict_scatter(act, c0, c1, c2));
    items_sent++;
  endtask

  task automatic stop_sending();
    pts.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    scatter_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        if (res.dst_rank !== exp_r.rank || res.buffer_addr !== exp_r.buf_addr ||
            res.source_addr !== exp_r.src_addr || res.error !== exp_r.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rank %0d buf %0h src %0h err %0b, got %0d %0h %0h %0b",
                     exp_r.rank, exp_r.buf_addr, exp_r.src_addr, exp_r.err,
                     res.dst_rank, res.buffer_addr, res.source_addr, res.error);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (sink_gaps) begin
      res.ready <= ($urandom_range(99) >= 25);
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic test_reset_defaults();
    send_point(ACT_CLEAR, 0, 0, 0);
    send_point(ACT_COUNT, 0, 0, 0);
    send_point(ACT_COUNT, 0, 0, 0);
    send_point(ACT_COUNT, 1, 0, 0);
    send_point(ACT_OFFSETS, 0, 0, 0);
    send_point(ACT_EMIT, 0, 0, 0);
    send_point(ACT_EMIT, 0, 0, 0);
    send_point(ACT_EMIT, 10'h3FF, 10'h3FF, 10'h3FF);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_IN_DIMS, 30'h3FFF_FFFF);
    write_reg(CFG_OUT_DIMS, 30'h3FFF_FFFF);
    write_reg(CFG_OWN_COORDS, 30'h0);
    write_reg(CFG_OUT_GRID, 30'h3FFFF);
    write_reg(CFG_IN_AXIS, 30'd3);
    write_reg(CFG_FIELDS, 30'd15);
    write_reg(CFG_SPARE_LO, 30'h3FFF_FFFF);
    write_reg(CFG_SPARE_HI, 30'h1555_5555);
    end_writes();
    send_point(ACT_COUNT, 10'd1022, 10'd1022, 10'd1022);
    send_point(ACT_EMIT, 10'd1022, 10'd0, 10'd1022);
    send_point(ACT_EMIT, 10'd1023, 10'd5, 10'd7);
    stop_sending();
    wait_drained();
    write_reg(CFG_OUT_DIMS, 30'h0);
    write_reg(CFG_FIELDS, 30'd0);
    write_reg(CFG_IN_AXIS, 30'd2);
    end_writes();
    send_point(ACT_COUNT, 10'd3, 10'd2, 10'd1);
    stop_sending();
    wait_drained();
    write_reg(CFG_IN_DIMS, {10'd64, 10'd64, 10'd64});
    write_reg(CFG_OUT_DIMS, {10'd1, 10'd1, 10'd1});
    write_reg(CFG_OWN_COORDS, 30'h3FFFF);
    write_reg(CFG_OUT_GRID, 30'h3FFFF);
    write_reg(CFG_FIELDS, 30'd8);
    write_reg(CFG_IN_AXIS, 30'd1);
    end_writes();
    send_point(ACT_EMIT, 10'd0, 10'd0, 10'd0);
    stop_sending();
    wait_drained();
    write_reg(CFG_OWN_COORDS, 30'h0);
    write_reg(CFG_OUT_DIMS, {10'd64, 10'd64, 10'd64});
    write_reg(CFG_OUT_GRID, {6'd1, 6'd1, 6'd1});
    end_writes();
    send_point(ACT_COUNT, 10'd63, 10'd0, 10'd0);
    send_point(ACT_OFFSETS, 0, 0, 0);
    send_point(ACT_EMIT, 10'd63, 10'd63, 10'd63);
    send_point(ACT_CLEAR, 0, 0, 0);
    stop_sending();
    wait_drained();
  endtask

  task automatic random_config();
    logic [DIM_BITS-1:0] n, od;
    logic [NODE_BITS-1:0] g, own;
    logic [DIMS_W-1:0] ind, outd;
    logic [GRID_W-1:0] ownc, grid;
    for (int k = 0; k < 3; k++) begin
      n = DIM_BITS'($urandom_range(1, 12));
      g = NODE_BITS'($urandom_range(1, 4));
      own = NODE_BITS'($urandom_range(0, g - 1));
      od = DIM_BITS'($urandom_range(n > 1 ? n - 1 : 1, n + 3));
      if ($urandom_range(99) < 3) od = '0;
      ind[k*DIM_BITS +: DIM_BITS] = n;
      outd[k*DIM_BITS +: DIM_BITS] = od;
      ownc[k*NODE_BITS +: NODE_BITS] = own;
      grid[k*NODE_BITS +: NODE_BITS] = g;
    end
    write_reg(CFG_IN_DIMS, CFG_W'(ind));
    write_reg(CFG_OUT_DIMS, CFG_W'(outd));
    write_reg(CFG_OWN_COORDS, CFG_W'(ownc));
    write_reg(CFG_OUT_GRID, CFG_W'(grid));
    write_reg(CFG_IN_AXIS, CFG_W'($urandom_range(0, 3)));
    write_reg(CFG_FIELDS, CFG_W'($urandom_range(0, 15)));
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom()));
    end_writes();
  endtask

  task automatic send_noise();
    send_point(act_t'($urandom_range(0, 3)), DIM_BITS'($urandom()), DIM_BITS'($urandom()),
               DIM_BITS'($urandom()));
  endtask

  task automatic run_phase();
    logic [DIM_BITS-1:0] pc0 [$];
    logic [DIM_BITS-1:0] pc1 [$];
    logic [DIM_BITS-1:0] pc2 [$];
    int count;
    count = $urandom_range(4, 20);
    random_config();
    send_point(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < count; i++) begin
      pc0.push_back(DIM_BITS'($urandom_range(0, in_dims_r[0 +: DIM_BITS])));
      pc1.push_back(DIM_BITS'($urandom_range(0, in_dims_r[DIM_BITS +: DIM_BITS])));
      pc2.push_back(DIM_BITS'($urandom_range(0, in_dims_r[2*DIM_BITS +: DIM_BITS])));
      send_point(ACT_COUNT, pc0[i], pc1[i], pc2[i]);
      if ($urandom_range(99) < 10) send_noise();
    end
    send_point(ACT_OFFSETS, 0, 0, 0);
    for (int i = count - 1; i >= 0; i--) begin
      send_point(ACT_EMIT, pc0[i], pc1[i], pc2[i]);
      if ($urandom_range(99) < 10) send_noise();
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_backpressure();
    random_config();
    hold_request = 300;
    for (int i = 0; i < 6; i++) send_point(ACT_COUNT, 0, 0, 0);
    send_point(ACT_OFFSETS, 0, 0, 0);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_phases();
    int phase = 0;
    while (items_sent < ITEM_TARGET) begin
      src_gaps = (phase % 6) >= 2;
      sink_gaps = (phase % 6) >= 2;
      run_phase();
      phase++;
    end
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    #20_000_000;
    $display("pencil_transpose_scatter_addresser test failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    write_enable <= 1'b0;
    reg_index <= '0;
    write_data <= '0;
    pts.valid <= 1'b0;
    pts.action <= ACT_CLEAR;
    pts.coord_0 <= '0;
    pts.coord_1 <= '0;
    pts.coord_2 <= '0;
    foreach (rank_table[i]) rank_table[i] = '0;
    in_dims_r = DIMS_RESET;
    out_dims_r = DIMS_RESET;
    own_r = '0;
    grid_r = GRID_RESET;
    axis_r = '0;
    fields_r = 4'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pencil_transpose_scatter_addresser test passed");
    end else begin
      $display("pencil_transpose_scatter_addresser test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
